[hw/rtl/mmt_pkg.sv]
package mmt_pkg;

    localparam int POS_W   = 32;
    localparam int COMP_W  = 16;
    localparam int PROD_W  = 32;
    localparam int ROT_W   = 34;
    localparam int SCL_W   = 50;
    localparam int FRAC_SH = 20;

    // 1.0 in the Q28 format of the rotation entries.
    localparam logic signed [ROT_W-1:0] ONE_Q28 = ROT_W'(64'sd1 <<< 28);
    // Half an output LSB in the Q36 format of the scaled entries.
    localparam logic signed [SCL_W-1:0] HALF_LSB = SCL_W'(64'sd1 <<< (FRAC_SH - 1));

    // Slots of the quaternion product array.
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int P_WX = 6;
    localparam int P_WY = 7;
    localparam int P_WZ = 8;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [COMP_W-1:0] quat_w;
        logic signed [COMP_W-1:0] quat_x;
        logic signed [COMP_W-1:0] quat_y;
        logic signed [COMP_W-1:0] quat_z;
        logic signed [COMP_W-1:0] scale_x;
        logic signed [COMP_W-1:0] scale_y;
        logic signed [COMP_W-1:0] scale_z;
    } xform_t;

    typedef struct packed {
        logic signed [POS_W-1:0] col0_row0;
        logic signed [POS_W-1:0] col0_row1;
        logic signed [POS_W-1:0] col0_row2;
        logic signed [POS_W-1:0] col1_row0;
        logic signed [POS_W-1:0] col1_row1;
        logic signed [POS_W-1:0] col1_row2;
        logic signed [POS_W-1:0] col2_row0;
        logic signed [POS_W-1:0] col2_row1;
        logic signed [POS_W-1:0] col2_row2;
        logic signed [POS_W-1:0] trans_x;
        logic signed [POS_W-1:0] trans_y;
        logic signed [POS_W-1:0] trans_z;
    } matrix_t;

endpackage

[hw/rtl/mmt_xform_if.sv]
interface mmt_xform_if
    import mmt_pkg::*;
();
    logic   valid;
    logic   ready;
    xform_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/mmt_matrix_if.sv]
interface mmt_matrix_if
    import mmt_pkg::*;
();
    logic    valid;
    logic    ready;
    matrix_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/model_matrix_from_trs.sv]
// Channel   Dir   Interface       Word
// xform     in    mmt_xform_if    position Q16.16, quaternion Q2.14, scale Q8.8
// matrix    out   mmt_matrix_if   3x3 scaled rotation Q16.16, translation Q16.16
//
// Four register stages: quaternion products, rotation entries, scale multiply,
// rounding into the output register. One word per cycle while the output is not stalled.
// Every stage has its own nine 16x16 multipliers, adders or 34x16 multipliers, so
// nothing is shared and a new word can enter each cycle. rst_n clears only the
// stage valid bits. Each stage loads when it is empty or its content moves on, so
// a stall at the output backs up stage by stage and bubbles are squeezed out.
module model_matrix_from_trs
    import mmt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mmt_xform_if.sink    xform,
    mmt_matrix_if.source matrix
);

    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic free1, free2, free3, free_o;

    logic signed [PROD_W-1:0] prod_reg [9];
    logic signed [PROD_W-1:0] prod_next [9];
    logic signed [ROT_W-1:0]  rot_reg [9];
    logic signed [ROT_W-1:0]  rot_next [9];
    logic signed [SCL_W-1:0]  scl_reg [9];
    logic signed [SCL_W-1:0]  scl_next [9];
    logic signed [POS_W-1:0]  ent_next [9];

    logic signed [COMP_W-1:0] s1_scale_reg [3];
    logic signed [COMP_W-1:0] s2_scale_reg [3];
    logic signed [POS_W-1:0]  s1_pos_reg [3];
    logic signed [POS_W-1:0]  s2_pos_reg [3];
    logic signed [POS_W-1:0]  s3_pos_reg [3];

    matrix_t out_reg;
    matrix_t out_next;

    assign free_o = !vo_reg || matrix.ready;
    assign free3  = !v3_reg || free_o;
    assign free2  = !v2_reg || free3;
    assign free1  = !v1_reg || free2;

    assign xform.ready  = free1;
    assign matrix.valid = vo_reg;
    assign matrix.data  = out_reg;

    // Stage 1: all pairwise quaternion products, exact in Q4.28.
    always_comb
    begin
        prod_next[P_XX] = PROD_W'(xform.data.quat_x * xform.data.quat_x);
        prod_next[P_YY] = PROD_W'(xform.data.quat_y * xform.data.quat_y);
        prod_next[P_ZZ] = PROD_W'(xform.data.quat_z * xform.data.quat_z);
        prod_next[P_XY] = PROD_W'(xform.data.quat_x * xform.data.quat_y);
        prod_next[P_XZ] = PROD_W'(xform.data.quat_x * xform.data.quat_z);
        prod_next[P_YZ] = PROD_W'(xform.data.quat_y * xform.data.quat_z);
        prod_next[P_WX] = PROD_W'(xform.data.quat_w * xform.data.quat_x);
        prod_next[P_WY] = PROD_W'(xform.data.quat_w * xform.data.quat_y);
        prod_next[P_WZ] = PROD_W'(xform.data.quat_w * xform.data.quat_z);
    end

    // Stage 2: rotation entries in column-major order, Q28.
    always_comb
    begin
        rot_next[0] = ONE_Q28 - ((ROT_W'(prod_reg[P_YY]) + ROT_W'(prod_reg[P_ZZ])) <<< 1);
        rot_next[1] = (ROT_W'(prod_reg[P_XY]) + ROT_W'(prod_reg[P_WZ])) <<< 1;
        rot_next[2] = (ROT_W'(prod_reg[P_XZ]) - ROT_W'(prod_reg[P_WY])) <<< 1;
        rot_next[3] = (ROT_W'(prod_reg[P_XY]) - ROT_W'(prod_reg[P_WZ])) <<< 1;
        rot_next[4] = ONE_Q28 - ((ROT_W'(prod_reg[P_XX]) + ROT_W'(prod_reg[P_ZZ])) <<< 1);
        rot_next[5] = (ROT_W'(prod_reg[P_YZ]) + ROT_W'(prod_reg[P_WX])) <<< 1;
        rot_next[6] = (ROT_W'(prod_reg[P_XZ]) + ROT_W'(prod_reg[P_WY])) <<< 1;
        rot_next[7] = (ROT_W'(prod_reg[P_YZ]) - ROT_W'(prod_reg[P_WX])) <<< 1;
        rot_next[8] = ONE_Q28 - ((ROT_W'(prod_reg[P_XX]) + ROT_W'(prod_reg[P_YY])) <<< 1);
    end

    // Stage 3: each column times its scale component, exact in Q36.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                scl_next[3*c + r] = SCL_W'(rot_reg[3*c + r]) * SCL_W'(s2_scale_reg[c]);
            end
        end
    end

    // Stage 4: round to nearest, ties up. The scaled entry is at most 2^47 in
    // magnitude, so the rounded Q16.16 value always lies inside 32 bits and the
    // saturation bound is never reached.
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            ent_next[i] = POS_W'((scl_reg[i] + HALF_LSB) >>> FRAC_SH);
        end
        out_next.col0_row0 = ent_next[0];
        out_next.col0_row1 = ent_next[1];
        out_next.col0_row2 = ent_next[2];
        out_next.col1_row0 = ent_next[3];
        out_next.col1_row1 = ent_next[4];
        out_next.col1_row2 = ent_next[5];
        out_next.col2_row0 = ent_next[6];
        out_next.col2_row1 = ent_next[7];
        out_next.col2_row2 = ent_next[8];
        out_next.trans_x   = s3_pos_reg[0];
        out_next.trans_y   = s3_pos_reg[1];
        out_next.trans_z   = s3_pos_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (free1)
            begin
                v1_reg <= xform.valid;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
            if (free_o)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free1)
        begin
            prod_reg        <= prod_next;
            s1_scale_reg[0] <= xform.data.scale_x;
            s1_scale_reg[1] <= xform.data.scale_y;
            s1_scale_reg[2] <= xform.data.scale_z;
            s1_pos_reg[0]   <= xform.data.pos_x;
            s1_pos_reg[1]   <= xform.data.pos_y;
            s1_pos_reg[2]   <= xform.data.pos_z;
        end
        if (free2)
        begin
            rot_reg      <= rot_next;
            s2_scale_reg <= s1_scale_reg;
            s2_pos_reg   <= s1_pos_reg;
        end
        if (free3)
        begin
            scl_reg    <= scl_next;
            s3_pos_reg <= s2_pos_reg;
        end
        if (free_o)
        begin
            out_reg <= out_next;
        end
    end

    // An empty output register lets every stage move, so the input is open.
    a_open_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !vo_reg |-> xform.ready)
        else $error("input blocked with empty output register");

    // A word blocked in stage 1 is neither dropped nor altered.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !free2) |=> (v1_reg && $stable(prod_reg[P_XY]) && $stable(s1_pos_reg[0])))
        else $error("stage 1 word lost under stall");

    // A word leaving stage 3 always lands in the output register.
    a_s3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && free_o) |=> vo_reg)
        else $error("stage 3 word lost");

    // A word blocked in stage 2 keeps its rotation entries and scale.
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !free3) |=> (v2_reg && $stable(rot_reg[0]) && $stable(s2_scale_reg[0])))
        else $error("stage 2 word lost under stall");

endmodule

[verif/tb_model_matrix_from_trs.sv]
module tb_model_matrix_from_trs
    import mmt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_HALF     = 2;
    localparam int     RESET_CYCLES = 7;
    localparam int     SETTLE_CYC   = 16;
    localparam int     CYCLE_LIMIT  = 500000;
    localparam int     MAX_WAIT     = 16;
    localparam longint UNIT_Q28     = 64'sd1 <<< 28;
    localparam longint HALF_OUT_LSB = 64'sd1 <<< 19;
    localparam int     Q14_ONE      = 16384;
    localparam int     Q14_COS45    = 11585;
    localparam int     Q8_ONE       = 256;

    logic clk;
    logic rst_n;

    mmt_xform_if  xform_ch ();
    mmt_matrix_if matrix_ch ();

    model_matrix_from_trs u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .xform  (xform_ch),
        .matrix (matrix_ch)
    );

    matrix_t expected_mats[$];
    matrix_t want_mat;
    int      fail_count = 0;
    int      cycle_count = 0;
    int      send_max_gap = 0;
    int      recv_max_stall = 0;
    int      recv_hold_request = 0;
    int      recv_stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** model_matrix_from_trs: FAILED **");
            $finish;
        end
    end

    function automatic int draw_wait(input int max_wait);
        if (max_wait == 0)
            return 0;
        return $urandom_range(max_wait, 0);
    endfunction

    // Rotation entry in Q28 times a Q8.8 scale gives Q36; round half up into Q16.16.
    function automatic logic signed [31:0] scaled_entry(input longint rot_q28,
                                                        input logic signed [15:0] s);
        longint prod;
        longint rounded;
        prod = rot_q28 * longint'(s);
        rounded = (prod + HALF_OUT_LSB) >>> 20;
        if (rounded > 64'sd2147483647)
            return 32'sh7fffffff;
        if (rounded < -64'sd2147483648)
            return 32'sh80000000;
        return 32'(rounded);
    endfunction

    function automatic matrix_t predict_matrix(input xform_t t);
        longint w, x, y, z;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
        matrix_t m;
        w = t.quat_w;
        x = t.quat_x;
        y = t.quat_y;
        z = t.quat_z;
        xx = x * x;
        yy = y * y;
        zz = z * z;
        xy = x * y;
        xz = x * z;
        yz = y * z;
        wx = w * x;
        wy = w * y;
        wz = w * z;
        m.col0_row0 = scaled_entry(UNIT_Q28 - 2 * (yy + zz), t.scale_x);
        m.col0_row1 = scaled_entry(2 * (xy + wz), t.scale_x);
        m.col0_row2 = scaled_entry(2 * (xz - wy), t.scale_x);
        m.col1_row0 = scaled_entry(2 * (xy - wz), t.scale_y);
        m.col1_row1 = scaled_entry(UNIT_Q28 - 2 * (xx + zz), t.scale_y);
        m.col1_row2 = scaled_entry(2 * (yz + wx), t.scale_y);
        m.col2_row0 = scaled_entry(2 * (xz + wy), t.scale_z);
        m.col2_row1 = scaled_entry(2 * (yz - wx), t.scale_z);
        m.col2_row2 = scaled_entry(UNIT_Q28 - 2 * (xx + yy), t.scale_z);
        m.trans_x = t.pos_x;
        m.trans_y = t.pos_y;
        m.trans_z = t.pos_z;
        return m;
    endfunction

    function automatic xform_t make_xform(input int px, input int py, input int pz,
                                          input int w, input int x, input int y,
                                          input int z, input int sx, input int sy,
                                          input int sz);
        xform_t t;
        t.pos_x = px;
        t.pos_y = py;
        t.pos_z = pz;
        t.quat_w = 16'(w);
        t.quat_x = 16'(x);
        t.quat_y = 16'(y);
        t.quat_z = 16'(z);
        t.scale_x = 16'(sx);
        t.scale_y = 16'(sy);
        t.scale_z = 16'(sz);
        return t;
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(5, 0))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(5, 0))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h00000000;
            3: return 32'hffffffff;
            4: return 32'h00000001;
            default: return $urandom;
        endcase
    endfunction

    function automatic int near_signed(input int base, input int spread);
        int v;
        v = base + int'($urandom_range(2 * spread, 0)) - spread;
        return $urandom_range(1, 0) ? v : -v;
    endfunction

    // A mix of raw words, words built from edge values, and transforms close to
    // a real rotation with a modest scale, which is what the block sees in use.
    function automatic xform_t random_xform();
        xform_t t;
        case ($urandom_range(9, 0)) inside
            [0:3]:
            begin
                t = make_xform($urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            [4:6]:
            begin
                t = make_xform(pick32(), pick32(), pick32(), pick16(), pick16(), pick16(),
                               pick16(), pick16(), pick16(), pick16());
            end
            default:
            begin
                t = make_xform($urandom, $urandom, $urandom,
                               near_signed(Q14_ONE / 2, Q14_ONE / 2),
                               near_signed(0, 9000), near_signed(0, 9000),
                               near_signed(0, 9000),
                               near_signed(Q8_ONE, Q8_ONE), near_signed(Q8_ONE, Q8_ONE),
                               near_signed(Q8_ONE, Q8_ONE));
            end
        endcase
        return t;
    endfunction

    task automatic send_xform(input xform_t t);
        int gap;
        gap = draw_wait(send_max_gap);
        if (gap > 0)
        begin
            xform_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        xform_ch.data <= t;
        xform_ch.valid <= 1'b1;
        do @(posedge clk); while (!xform_ch.ready);
        expected_mats.push_back(predict_matrix(t));
    endtask

    task automatic wait_drained();
        xform_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_mats.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_entry(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result side: one ready decision per cycle, so a long hold-off can start
    // even while a matrix is waiting at the output.
    initial
    begin
        matrix_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && matrix_ch.valid && matrix_ch.ready)
                recv_stall_left = draw_wait(recv_max_stall);
            if (recv_hold_request > 0)
            begin
                recv_stall_left = recv_hold_request;
                recv_hold_request = 0;
            end
            if (recv_stall_left > 0)
            begin
                matrix_ch.ready <= 1'b0;
                recv_stall_left--;
            end
            else
                matrix_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && matrix_ch.valid && matrix_ch.ready)
        begin
            if (expected_mats.size() == 0)
            begin
                $error("matrix word with no transform outstanding");
                fail_count++;
            end
            else
            begin
                want_mat = expected_mats.pop_front();
                check_entry("col0_row0", want_mat.col0_row0, matrix_ch.data.col0_row0);
                check_entry("col0_row1", want_mat.col0_row1, matrix_ch.data.col0_row1);
                check_entry("col0_row2", want_mat.col0_row2, matrix_ch.data.col0_row2);
                check_entry("col1_row0", want_mat.col1_row0, matrix_ch.data.col1_row0);
                check_entry("col1_row1", want_mat.col1_row1, matrix_ch.data.col1_row1);
                check_entry("col1_row2", want_mat.col1_row2, matrix_ch.data.col1_row2);
                check_entry("col2_row0", want_mat.col2_row0, matrix_ch.data.col2_row0);
                check_entry("col2_row1", want_mat.col2_row1, matrix_ch.data.col2_row1);
                check_entry("col2_row2", want_mat.col2_row2, matrix_ch.data.col2_row2);
                check_entry("trans_x", want_mat.trans_x, matrix_ch.data.trans_x);
                check_entry("trans_y", want_mat.trans_y, matrix_ch.data.trans_y);
                check_entry("trans_z", want_mat.trans_z, matrix_ch.data.trans_z);
            end
        end
    end

    task automatic test_directed();
        send_max_gap = 0;
        recv_max_stall = 0;
        // Identity rotation with unit scale, then the position extremes.
        send_xform(make_xform(0, 0, 0, Q14_ONE, 0, 0, 0, Q8_ONE, Q8_ONE, Q8_ONE));
        send_xform(make_xform(32'h7fffffff, 32'h80000000, -1, Q14_ONE, 0, 0, 0,
                              Q8_ONE, Q8_ONE, Q8_ONE));
        send_xform(make_xform(1, 32'h10000, -32'sh10000, Q14_ONE, 0, 0, 0,
                              Q8_ONE, Q8_ONE, Q8_ONE));
        // Scale extremes on an identity rotation.
        send_xform(make_xform(0, 0, 0, Q14_ONE, 0, 0, 0, 32767, -32768, 1));
        send_xform(make_xform(0, 0, 0, Q14_ONE, 0, 0, 0, 0, -1, -Q8_ONE));
        // Quarter turns about each axis and half turns about each axis.
        send_xform(make_xform(5, 6, 7, Q14_COS45, Q14_COS45, 0, 0, Q8_ONE, Q8_ONE, Q8_ONE));
        send_xform(make_xform(5, 6, 7, Q14_COS45, 0, Q14_COS45, 0, Q8_ONE, Q8_ONE, Q8_ONE));
        send_xform(make_xform(5, 6, 7, Q14_COS45, 0, 0, Q14_COS45, Q8_ONE, Q8_ONE, Q8_ONE));
        send_xform(make_xform(0, 0, 0, 0, Q14_ONE, 0, 0, 512, 384, 128));
        send_xform(make_xform(0, 0, 0, 0, 0, Q14_ONE, 0, 512, 384, 128));
        send_xform(make_xform(0, 0, 0, 0, 0, 0, Q14_ONE, 512, 384, 128));
        send_xform(make_xform(0, 0, 0, -Q14_ONE, 0, 0, 0, Q8_ONE, Q8_ONE, Q8_ONE));
        // Quaternions far from unit length are used as they are.
        send_xform(make_xform(0, 0, 0, -32768, -32768, -32768, -32768, 32767, 32767, 32767));
        send_xform(make_xform(0, 0, 0, 32767, 32767, 32767, 32767, -32768, -32768, -32768));
        send_xform(make_xform(-1, -1, -1, -32768, 32767, -32768, 32767, -32768, 32767, 0));
        send_xform(make_xform(0, 0, 0, 0, 0, 0, 0, -1, -1, -1));
        send_xform(make_xform(0, 0, 0, 1, 0, 0, 0, 1, 1, 1));
        // Exact halves of an output step: the positive one rounds up, the
        // negative one rounds toward plus infinity as well.
        send_xform(make_xform(0, 0, 0, 0, 512, 512, 0, 1, -1, 1));
        send_xform(make_xform(0, 0, 0, 0, 512, -512, 0, 1, -1, 1));
        send_xform(make_xform(0, 0, 0, 0, -512, 512, 512, -1, 1, -1));
        wait_drained();
    endtask

    task automatic test_back_to_back(input int count);
        send_max_gap = 0;
        recv_max_stall = 0;
        repeat (count) send_xform(random_xform());
    endtask

    task automatic test_random_idle(input int count);
        send_max_gap = MAX_WAIT;
        recv_max_stall = MAX_WAIT;
        repeat (count) send_xform(random_xform());
    endtask

    // The output is held off long enough that every stage fills and the input
    // stalls while words keep being offered.
    task automatic test_output_backpressure(input int held_count, input int stalled_count);
        send_max_gap = 0;
        recv_max_stall = 0;
        recv_hold_request = 300;
        repeat (held_count) send_xform(random_xform());
        recv_max_stall = MAX_WAIT;
        repeat (stalled_count) send_xform(random_xform());
    endtask

    task automatic test_source_pause(input int count);
        send_max_gap = 8;
        recv_max_stall = 4;
        for (int i = 0; i < count; i++)
        begin
            send_xform(random_xform());
            if (i % 47 == 46)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        xform_ch.valid <= 1'b0;
        xform_ch.data <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_back_to_back(400);
        test_random_idle(600);
        test_output_backpressure(60, 300);
        test_source_pause(470);

        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);
        if (fail_count == 0)
            $display("** model_matrix_from_trs: PASSED **");
        else
            $display("** model_matrix_from_trs: FAILED **");
        $finish;
    end

endmodule
